[src/uca_pkg.sv]
// shared constants, types and tables for the two-circle union area pipeline
// depends on nothing; used by all modules of the block
`timescale 1ns / 1ps
`default_nettype none
package uca_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned AREA_WIDTH       = 41;
  localparam int unsigned NORM_BITS        = 31;

  // square root chain: one result bit per cell
  localparam int unsigned SQ_STEPS = NORM_BITS;
  localparam int unsigned RAD_W    = 2 * NORM_BITS;
  localparam int unsigned REM_W    = NORM_BITS + 2;
  localparam int unsigned ROOT_W   = NORM_BITS;

  // cordic datapath
  localparam int unsigned X_W = NORM_BITS + 3;
  localparam int unsigned Z_W = 28;
  localparam int unsigned T_W = 26;
  localparam logic [T_W-1:0] PI_Q24 = T_W'(52707179);

  // circle area: r^2 * 3.14 * 256 written as 20096 / 25
  localparam logic [14:0] AREA_PI_Q = 15'd20096;
  localparam logic [29:0] DIV5_M    = 30'd858993460;
  localparam logic [27:0] DIV25_M   = 28'd171798692;

  typedef enum logic [1:0] {
    REL_DISJOINT = 2'd0,
    REL_INSIDE   = 2'd1,
    REL_OVERLAP  = 2'd2
  } rel_e;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } cordic_t;

  // arctangent of 2^-i in q2.24, rounded to nearest
  function automatic logic [24:0] atan_q24(input logic [4:0] idx);
    logic [24:0] v;
    case (idx)
      5'd0:  v = 25'd13176795;
      5'd1:  v = 25'd7778716;
      5'd2:  v = 25'd4110060;
      5'd3:  v = 25'd2086331;
      5'd4:  v = 25'd1047214;
      5'd5:  v = 25'd524117;
      5'd6:  v = 25'd262123;
      5'd7:  v = 25'd131069;
      5'd8:  v = 25'd65536;
      5'd9:  v = 25'd32768;
      5'd10: v = 25'd16384;
      5'd11: v = 25'd8192;
      5'd12: v = 25'd4096;
      5'd13: v = 25'd2048;
      5'd14: v = 25'd1024;
      5'd15: v = 25'd512;
      5'd16: v = 25'd256;
      5'd17: v = 25'd128;
      5'd18: v = 25'd64;
      5'd19: v = 25'd32;
      5'd20: v = 25'd16;
      5'd21: v = 25'd8;
      5'd22: v = 25'd4;
      5'd23: v = 25'd2;
      5'd24: v = 25'd1;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/uca_sqrt_cell.sv]
// one cell of the integer square root chain: one root bit per cycle
// depends on uca_pkg
`timescale 1ns / 1ps
`default_nettype none
module uca_sqrt_cell (
  input  wire logic           clk_i,
  input  uca_pkg::sqrt_t      cell_i,
  output uca_pkg::sqrt_t      cell_o
);

  uca_pkg::sqrt_t cell_d, cell_q;
  logic [uca_pkg::REM_W+1:0] cur;
  logic [uca_pkg::REM_W+1:0] trial;

  always_comb begin
    cur   = {cell_i.rem, cell_i.rad[uca_pkg::RAD_W-1 -: 2]};
    trial = (uca_pkg::REM_W+2)'({cell_i.root, 2'b01});
    cell_d.rad = cell_i.rad << 2;
    if (cur >= trial) begin
      cell_d.rem  = uca_pkg::REM_W'(cur - trial);
      cell_d.root = {cell_i.root[uca_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      cell_d.rem  = uca_pkg::REM_W'(cur);
      cell_d.root = {cell_i.root[uca_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

[src/uca_cordic_cell.sv]
// one vectoring step of the half-angle cordic chain
// depends on uca_pkg (types, arctangent table)
`timescale 1ns / 1ps
`default_nettype none
module uca_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic           clk_i,
  input  uca_pkg::cordic_t    cell_i,
  output uca_pkg::cordic_t    cell_o
);

  uca_pkg::cordic_t cell_d, cell_q;
  logic signed [uca_pkg::X_W-1:0] xs, ys;
  logic signed [uca_pkg::Z_W-1:0] at;

  always_comb begin
    xs = cell_i.x >>> STEP;
    ys = cell_i.y >>> STEP;
    at = uca_pkg::Z_W'(uca_pkg::atan_q24(5'(STEP)));
    // positive y rotates clockwise
    if (cell_i.y > 0) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + at;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

[src/uca_circle_area.sv]
// five-stage circle area r^2 * 3.14 in q8 with round to nearest
// depends on uca_pkg (constants)
`timescale 1ns / 1ps
`default_nettype none
module uca_circle_area #(
  parameter int unsigned RW = uca_pkg::COORD_WIDTH_DEF - 1
) (
  input  wire logic                clk_i,
  input  wire logic [RW-1:0]       r_i,
  output logic      [2*RW+9:0]     area_o
);

  localparam int unsigned AW5 = RW - 2;
  localparam int unsigned CW  = RW + 5;
  localparam int unsigned EW  = RW + 1;
  localparam int unsigned SW  = 2 * RW - 3;
  localparam int unsigned AIW = 2 * RW + 10;

  // r = 5a + b, r^2 = 25a^2 + c, c = 25e + f
  logic [RW+29:0]   p5;
  logic [AW5-1:0]   a_q;
  logic [RW-1:0]    r_q;
  logic [RW-1:0]    bfull;
  logic [2:0]       b;
  logic [RW+1:0]    tenab;
  logic [CW-1:0]    c_d, c_q, c2_q;
  logic [2*AW5-1:0] asq_q, asq2_q;
  logic [CW+27:0]   p25;
  logic [EW-1:0]    e_q;
  logic [CW-1:0]    ffull;
  logic [SW-1:0]    s_q;
  logic [4:0]       f_q;
  logic [SW+14:0]   prod;
  logic [AIW-1:0]   area_q;

  // floor((20096 f + 12) / 25) for f below 25
  function automatic logic [14:0] area_frac(input logic [4:0] f);
    logic [14:0] v;
    case (f)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd804;
      5'd2:  v = 15'd1608;
      5'd3:  v = 15'd2412;
      5'd4:  v = 15'd3215;
      5'd5:  v = 15'd4019;
      5'd6:  v = 15'd4823;
      5'd7:  v = 15'd5627;
      5'd8:  v = 15'd6431;
      5'd9:  v = 15'd7235;
      5'd10: v = 15'd8038;
      5'd11: v = 15'd8842;
      5'd12: v = 15'd9646;
      5'd13: v = 15'd10450;
      5'd14: v = 15'd11254;
      5'd15: v = 15'd12058;
      5'd16: v = 15'd12861;
      5'd17: v = 15'd13665;
      5'd18: v = 15'd14469;
      5'd19: v = 15'd15273;
      5'd20: v = 15'd16077;
      5'd21: v = 15'd16881;
      5'd22: v = 15'd17684;
      5'd23: v = 15'd18488;
      5'd24: v = 15'd19292;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  always_comb begin
    p5    = (RW+30)'(r_i) * (RW+30)'(uca_pkg::DIV5_M);
    bfull = r_q - RW'(a_q) * RW'(5);
    b     = bfull[2:0];
    tenab = (RW+2)'(a_q) * (RW+2)'(10) + (RW+2)'(b);
    c_d   = CW'(tenab) * CW'(b);
    p25   = (CW+28)'(c_q) * (CW+28)'(uca_pkg::DIV25_M);
    ffull = c2_q - CW'(e_q) * CW'(25);
    prod  = (SW+15)'(s_q) * (SW+15)'(uca_pkg::AREA_PI_Q)
          + (SW+15)'(area_frac(f_q));
  end

  always_ff @(posedge clk_i) begin
    a_q    <= p5[RW+29:32];
    r_q    <= r_i;
    c_q    <= c_d;
    asq_q  <= a_q * a_q;
    c2_q   <= c_q;
    asq2_q <= asq_q;
    e_q    <= p25[CW+EW+31-CW:32];
    s_q    <= SW'(asq2_q) + SW'(e_q);
    f_q    <= ffull[4:0];
    area_q <= prod[AIW-1:0];
  end

  assign area_o = area_q;

endmodule
`default_nettype wire

[src/two_circle_union_area.sv]
// two_circle_union_area: area of the union of two circles in q8
// start reaches done_o through stages s1 to s8, the 31-cell square root chain, the cordic
// chain and stages p1 to p5; one item per cycle, busy never rises
// the result is on union_area_o and relation_o for the single cycle done_o is high;
// the receiver cannot stall, so nothing holds back the pipeline
// rst_ni clears only the valid pipeline; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module two_circle_union_area #(
  parameter int unsigned COORD_WIDTH  = uca_pkg::COORD_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = uca_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_WIDTH-1:0]       first_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       first_y_i,
  input  wire logic        [COORD_WIDTH-2:0]       first_radius_i,
  input  wire logic signed [COORD_WIDTH-1:0]       second_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       second_y_i,
  input  wire logic        [COORD_WIDTH-2:0]       second_radius_i,
  output logic                                     done_o,
  output logic [uca_pkg::AREA_WIDTH-1:0]           union_area_o,
  output logic [1:0]                               relation_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned RW   = W - 1;
  localparam int unsigned SQW  = 2 * RW;
  localparam int unsigned MW   = 2 * W + 2;
  localparam int unsigned NCH  = (MW + 7) / 8;
  localparam int unsigned SWD  = MW + 32;
  localparam int unsigned AIW  = 2 * RW + 10;
  localparam int unsigned ASW  = AIW + 1;
  localparam int unsigned NB   = uca_pkg::NORM_BITS;
  localparam int unsigned DA   = uca_pkg::SQ_STEPS + 1;
  localparam int unsigned DL   = DA + CORDIC_STEPS;
  localparam int unsigned HTW  = 2 * W + 38;
  localparam int unsigned PPW  = RW + uca_pkg::T_W;
  localparam int unsigned TW   = 2 * RW + uca_pkg::T_W + 1;
  localparam int unsigned LNW  = 2 * RW + 12;
  localparam int unsigned XW   = (ASW > uca_pkg::AREA_WIDTH) ? ASW : uca_pkg::AREA_WIDTH;
  localparam int unsigned T_W  = uca_pkg::T_W;
  localparam int unsigned Z_W  = uca_pkg::Z_W;
  localparam int unsigned X_W  = uca_pkg::X_W;

  // --------------------------------------------------------------------------
  // handshake: every cycle can take a transfer
  // --------------------------------------------------------------------------
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  // highest set bit position plus one of a byte
  function automatic logic [3:0] byte_len(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      if (v[b]) n = 4'(b + 1);
    end
    return n;
  endfunction

  // bring a value to the common 31-bit scale
  function automatic logic [NB-1:0] norm_f(input logic [MW-1:0] v,
                                           input logic signed [6:0] s);
    logic [SWD-1:0] w;
    logic [5:0]     k;
    k = 6'd0;
    if (s < 0) begin
      k = 6'(-s);
      w = SWD'(v) << k;
    end else begin
      w = SWD'(v) >> s;
    end
    return w[NB-1:0];
  endfunction

  // half the triangle term in q8, scaled back by the common shift
  function automatic logic [HTW-1:0] hterm_f(input logic [NB-1:0] h,
                                             input logic signed [6:0] s);
    logic [HTW-1:0] w;
    logic [5:0]     k;
    k = 6'd0;
    w = HTW'(h) << 7;
    if (s > 0) begin
      w = w << s;
    end else if (s < 0) begin
      k = 6'(-s);
      w = (w + (HTW'(1) << (k - 6'd1))) >> k;
    end
    return w;
  endfunction

  // mirror for obtuse half-angles, then clamp to [0, pi]
  function automatic logic [T_W-1:0] angle_f(input logic signed [Z_W-1:0] z,
                                             input logic neg);
    logic signed [Z_W-1:0] v;
    logic signed [Z_W-1:0] pi_s;
    pi_s = Z_W'(uca_pkg::PI_Q24);
    v    = neg ? pi_s - z : z;
    if (v < 0) v = '0;
    if (v > pi_s) v = pi_s;
    return T_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // s1: center deltas
  // --------------------------------------------------------------------------
  logic              v1_q;
  logic signed [W:0] dx_q, dy_q;
  logic [RW-1:0]     r1_q, r2_q;

  always_ff @(posedge clk_i) begin
    dx_q <= {second_x_i[W-1], second_x_i} - {first_x_i[W-1], first_x_i};
    dy_q <= {second_y_i[W-1], second_y_i} - {first_y_i[W-1], first_y_i};
    r1_q <= first_radius_i;
    r2_q <= second_radius_i;
  end

  // --------------------------------------------------------------------------
  // s2: squares
  // --------------------------------------------------------------------------
  logic              v2_q;
  logic [W:0]        ax, ay;
  logic [W-1:0]      rs;
  logic [RW-1:0]     rd;
  logic [2*W+1:0]    axsq_q, aysq_q;
  logic [2*W-1:0]    rssq_q, rssq3_q;
  logic [SQW-1:0]    rdsq_q, rdsq3_q;
  logic [SQW-1:0]    r1sq2_q, r2sq2_q, r1sq3_q, r2sq3_q;

  always_comb begin
    ax = dx_q[W] ? (W+1)'(-dx_q) : (W+1)'(dx_q);
    ay = dy_q[W] ? (W+1)'(-dy_q) : (W+1)'(dy_q);
    rs = W'(r1_q) + W'(r2_q);
    rd = (r1_q > r2_q) ? r1_q - r2_q : r2_q - r1_q;
  end

  always_ff @(posedge clk_i) begin
    axsq_q  <= (2*W+2)'(ax) * (2*W+2)'(ax);
    aysq_q  <= (2*W+2)'(ay) * (2*W+2)'(ay);
    rssq_q  <= (2*W)'(rs) * (2*W)'(rs);
    rdsq_q  <= SQW'(rd) * SQW'(rd);
    r1sq2_q <= SQW'(r1_q) * SQW'(r1_q);
    r2sq2_q <= SQW'(r2_q) * SQW'(r2_q);
  end

  // --------------------------------------------------------------------------
  // s3: squared center distance
  // --------------------------------------------------------------------------
  logic          v3_q;
  logic [MW-1:0] d2_q;

  always_ff @(posedge clk_i) begin
    d2_q    <= MW'(axsq_q) + MW'(aysq_q);
    rssq3_q <= rssq_q;
    rdsq3_q <= rdsq_q;
    r1sq3_q <= r1sq2_q;
    r2sq3_q <= r2sq2_q;
  end

  // --------------------------------------------------------------------------
  // s4: classify and form the lens operands
  // --------------------------------------------------------------------------
  logic             v4_q;
  uca_pkg::rel_e    rel_d, rel4_q, rel5_q, rel6_q, rel7_q;
  logic signed [MW:0] n1, n2;
  logic [MW-1:0]    p4_q, q4_q, m14_q, m24_q;
  logic             neg14_q, neg24_q;
  logic [SQW-1:0]   r1sq4_q, r2sq4_q;

  always_comb begin
    // tangent from outside counts as disjoint, from inside as inside
    if (d2_q >= MW'(rssq3_q)) begin
      rel_d = uca_pkg::REL_DISJOINT;
    end else if (d2_q <= MW'(rdsq3_q)) begin
      rel_d = uca_pkg::REL_INSIDE;
    end else begin
      rel_d = uca_pkg::REL_OVERLAP;
    end
    n1 = (MW+1)'(r1sq3_q) - (MW+1)'(r2sq3_q) + (MW+1)'(d2_q);
    n2 = (MW+1)'(r2sq3_q) - (MW+1)'(r1sq3_q) + (MW+1)'(d2_q);
  end

  always_ff @(posedge clk_i) begin
    rel4_q  <= rel_d;
    p4_q    <= d2_q - MW'(rdsq3_q);
    q4_q    <= MW'(rssq3_q) - d2_q;
    neg14_q <= n1[MW];
    neg24_q <= n2[MW];
    m14_q   <= n1[MW] ? MW'(-n1) : MW'(n1);
    m24_q   <= n2[MW] ? MW'(-n2) : MW'(n2);
    r1sq4_q <= r1sq3_q;
    r2sq4_q <= r2sq3_q;
  end

  // --------------------------------------------------------------------------
  // s5, s6: leading one of the largest operand, byte by byte
  // --------------------------------------------------------------------------
  logic              v5_q, v6_q, v7_q;
  logic [NCH*8-1:0]  orw;
  logic [3:0]        blen5_q [NCH];
  logic [MW-1:0]     p5_q, q5_q, m15_q, m25_q, p6_q, q6_q, m16_q, m26_q;
  logic              neg15_q, neg25_q, neg16_q, neg26_q, neg17_q, neg27_q;
  logic [SQW-1:0]    r1sq5_q, r2sq5_q, r1sq6_q, r2sq6_q, r1sq7_q, r2sq7_q;
  logic [6:0]        blen;
  logic signed [6:0] sh6_q, sh7_q;

  assign orw = (NCH*8)'(p4_q | q4_q | m14_q | m24_q);

  always_comb begin
    blen = 7'd0;
    for (int c = 0; c < NCH; c++) begin
      if (blen5_q[c] != 4'd0) blen = 7'(c * 8) + 7'(blen5_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCH; c++) begin
      blen5_q[c] <= byte_len(orw[c*8 +: 8]);
    end
    p5_q    <= p4_q;
    q5_q    <= q4_q;
    m15_q   <= m14_q;
    m25_q   <= m24_q;
    neg15_q <= neg14_q;
    neg25_q <= neg24_q;
    rel5_q  <= rel4_q;
    r1sq5_q <= r1sq4_q;
    r2sq5_q <= r2sq4_q;

    sh6_q   <= signed'(blen - 7'(NB));
    p6_q    <= p5_q;
    q6_q    <= q5_q;
    m16_q   <= m15_q;
    m26_q   <= m25_q;
    neg16_q <= neg15_q;
    neg26_q <= neg25_q;
    rel6_q  <= rel5_q;
    r1sq6_q <= r1sq5_q;
    r2sq6_q <= r2sq5_q;
  end

  // --------------------------------------------------------------------------
  // circle areas, aligned to s6
  // --------------------------------------------------------------------------
  logic [AIW-1:0] a1, a2;
  logic [ASW-1:0] asum7_q, amax7_q;

  uca_circle_area #(.RW(RW)) u_area1 (.clk_i(clk_i), .r_i(r1_q), .area_o(a1));
  uca_circle_area #(.RW(RW)) u_area2 (.clk_i(clk_i), .r_i(r2_q), .area_o(a2));

  // --------------------------------------------------------------------------
  // s7: normalized operands
  // --------------------------------------------------------------------------
  logic [NB-1:0] pn_q, qn_q, m1n_q, m2n_q;

  always_ff @(posedge clk_i) begin
    pn_q    <= norm_f(p6_q, sh6_q);
    qn_q    <= norm_f(q6_q, sh6_q);
    m1n_q   <= norm_f(m16_q, sh6_q);
    m2n_q   <= norm_f(m26_q, sh6_q);
    sh7_q   <= sh6_q;
    neg17_q <= neg16_q;
    neg27_q <= neg26_q;
    rel7_q  <= rel6_q;
    r1sq7_q <= r1sq6_q;
    r2sq7_q <= r2sq6_q;
    asum7_q <= ASW'(a1) + ASW'(a2);
    amax7_q <= (a1 > a2) ? ASW'(a1) : ASW'(a2);
  end

  // --------------------------------------------------------------------------
  // s8 and square root chain: h = floor(sqrt(p * q))
  // --------------------------------------------------------------------------
  logic [uca_pkg::RAD_W-1:0] prod_q;
  uca_pkg::sqrt_t            sq_s [uca_pkg::SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    prod_q <= uca_pkg::RAD_W'(pn_q) * uca_pkg::RAD_W'(qn_q);
  end

  assign sq_s[0] = '{rem: '0, root: '0, rad: prod_q};

  for (genvar k = 0; k < uca_pkg::SQ_STEPS; k++) begin : g_sqrt
    uca_sqrt_cell u_cell (.clk_i(clk_i), .cell_i(sq_s[k]), .cell_o(sq_s[k+1]));
  end

  // --------------------------------------------------------------------------
  // side data delay lines: common line to the end of the cordic chain,
  // adjacent sides to the cordic entry, h through the cordic chain
  // --------------------------------------------------------------------------
  logic              vl_q    [DL];
  logic              negl1_q [DL];
  logic              negl2_q [DL];
  logic signed [6:0] shl_q   [DL];
  uca_pkg::rel_e     rell_q  [DL];
  logic [SQW-1:0]    r1sql_q [DL];
  logic [SQW-1:0]    r2sql_q [DL];
  logic [ASW-1:0]    asuml_q [DL];
  logic [ASW-1:0]    amaxl_q [DL];
  logic [NB-1:0]     m1l_q   [DA];
  logic [NB-1:0]     m2l_q   [DA];
  logic [NB-1:0]     hl_q    [CORDIC_STEPS];
  logic [NB-1:0]     h_root;

  assign h_root = sq_s[uca_pkg::SQ_STEPS].root;

  always_ff @(posedge clk_i) begin
    negl1_q[0] <= neg17_q;
    negl2_q[0] <= neg27_q;
    shl_q[0]   <= sh7_q;
    rell_q[0]  <= rel7_q;
    r1sql_q[0] <= r1sq7_q;
    r2sql_q[0] <= r2sq7_q;
    asuml_q[0] <= asum7_q;
    amaxl_q[0] <= amax7_q;
    for (int i = 1; i < DL; i++) begin
      negl1_q[i] <= negl1_q[i-1];
      negl2_q[i] <= negl2_q[i-1];
      shl_q[i]   <= shl_q[i-1];
      rell_q[i]  <= rell_q[i-1];
      r1sql_q[i] <= r1sql_q[i-1];
      r2sql_q[i] <= r2sql_q[i-1];
      asuml_q[i] <= asuml_q[i-1];
      amaxl_q[i] <= amaxl_q[i-1];
    end
    m1l_q[0] <= m1n_q;
    m2l_q[0] <= m2n_q;
    for (int i = 1; i < DA; i++) begin
      m1l_q[i] <= m1l_q[i-1];
      m2l_q[i] <= m2l_q[i-1];
    end
    hl_q[0] <= h_root;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      hl_q[i] <= hl_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // cordic chains: half-angles atan2(h, |n1|) and atan2(h, |n2|)
  // --------------------------------------------------------------------------
  uca_pkg::cordic_t c1_s [CORDIC_STEPS+1];
  uca_pkg::cordic_t c2_s [CORDIC_STEPS+1];

  assign c1_s[0] = '{x: X_W'(m1l_q[DA-1]), y: X_W'(h_root), z: '0};
  assign c2_s[0] = '{x: X_W'(m2l_q[DA-1]), y: X_W'(h_root), z: '0};

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    uca_cordic_cell #(.STEP(j)) u_cell1 (
      .clk_i (clk_i),
      .cell_i(c1_s[j]),
      .cell_o(c1_s[j+1])
    );
    uca_cordic_cell #(.STEP(j)) u_cell2 (
      .clk_i (clk_i),
      .cell_i(c2_s[j]),
      .cell_o(c2_s[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // p1: final angles and the triangle term
  // --------------------------------------------------------------------------
  logic            vp1_q, vp2_q, vp3_q, vp4_q, vp5_q;
  logic [T_W-1:0]  t1_q, t2_q;
  logic [HTW-1:0]  ht1_q, ht2_q, ht3_q;
  logic [SQW-1:0]  r1sqp_q, r2sqp_q;
  logic [ASW-1:0]  asum1_q, asum2_q, asum3_q, asum4_q;
  logic [ASW-1:0]  amax1_q, amax2_q, amax3_q, amax4_q;
  uca_pkg::rel_e   relp1_q, relp2_q, relp3_q, relp4_q;

  always_ff @(posedge clk_i) begin
    t1_q    <= angle_f(c1_s[CORDIC_STEPS].z, negl1_q[DL-1]);
    t2_q    <= angle_f(c2_s[CORDIC_STEPS].z, negl2_q[DL-1]);
    ht1_q   <= hterm_f(hl_q[CORDIC_STEPS-1], shl_q[DL-1]);
    r1sqp_q <= r1sql_q[DL-1];
    r2sqp_q <= r2sql_q[DL-1];
    asum1_q <= asuml_q[DL-1];
    amax1_q <= amaxl_q[DL-1];
    relp1_q <= rell_q[DL-1];
  end

  // --------------------------------------------------------------------------
  // p2: partial products r^2 * t, split at the radius width
  // --------------------------------------------------------------------------
  logic [PPW-1:0] pp1h_q, pp1l_q, pp2h_q, pp2l_q;

  always_ff @(posedge clk_i) begin
    pp1h_q  <= PPW'(r1sqp_q[SQW-1:RW]) * PPW'(t1_q);
    pp1l_q  <= PPW'(r1sqp_q[RW-1:0]) * PPW'(t1_q);
    pp2h_q  <= PPW'(r2sqp_q[SQW-1:RW]) * PPW'(t2_q);
    pp2l_q  <= PPW'(r2sqp_q[RW-1:0]) * PPW'(t2_q);
    ht2_q   <= ht1_q;
    asum2_q <= asum1_q;
    amax2_q <= amax1_q;
    relp2_q <= relp1_q;
  end

  // --------------------------------------------------------------------------
  // p3: sector terms rounded to q8, summed
  // --------------------------------------------------------------------------
  logic [TW-1:0]  s1w, s2w;
  logic [LNW-1:0] tot_q;

  always_comb begin
    s1w = (TW'(pp1h_q) << RW) + TW'(pp1l_q) + (TW'(1) << 15);
    s2w = (TW'(pp2h_q) << RW) + TW'(pp2l_q) + (TW'(1) << 15);
  end

  always_ff @(posedge clk_i) begin
    tot_q   <= LNW'(s1w[TW-1:16]) + LNW'(s2w[TW-1:16]);
    ht3_q   <= ht2_q;
    asum3_q <= asum2_q;
    amax3_q <= amax2_q;
    relp3_q <= relp2_q;
  end

  // --------------------------------------------------------------------------
  // p4: lens, saturated at zero when rounding drives it negative
  // --------------------------------------------------------------------------
  logic [LNW-1:0] lens_q;
  logic [HTW-1:0] totw;
  logic [HTW-1:0] lensw;

  always_comb begin
    totw  = HTW'(tot_q);
    lensw = totw - ht3_q;
  end

  always_ff @(posedge clk_i) begin
    lens_q  <= (totw > ht3_q) ? LNW'(lensw) : '0;
    asum4_q <= asum3_q;
    amax4_q <= amax3_q;
    relp4_q <= relp3_q;
  end

  // --------------------------------------------------------------------------
  // p5: pick the result by relation, area wraps to the output width
  // --------------------------------------------------------------------------
  logic [LNW-1:0]                   asumw, ovw;
  logic [ASW-1:0]                   area_fin;
  logic [XW-1:0]                    area_x;
  logic [uca_pkg::AREA_WIDTH-1:0]   union_q;
  uca_pkg::rel_e                    relo_q;

  always_comb begin
    asumw = LNW'(asum4_q);
    ovw   = asumw - lens_q;
    case (relp4_q)
      uca_pkg::REL_DISJOINT: area_fin = asum4_q;
      uca_pkg::REL_INSIDE:   area_fin = amax4_q;
      uca_pkg::REL_OVERLAP:  area_fin = (asumw > lens_q) ? ASW'(ovw) : '0;
      default:               area_fin = '0;
    endcase
    area_x = XW'(area_fin);
  end

  always_ff @(posedge clk_i) begin
    union_q <= area_x[uca_pkg::AREA_WIDTH-1:0];
    relo_q  <= relp4_q;
  end

  // --------------------------------------------------------------------------
  // valid pipeline, the only reset state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      for (int i = 0; i < DL; i++) vl_q[i] <= 1'b0;
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vp3_q <= 1'b0;
      vp4_q <= 1'b0;
      vp5_q <= 1'b0;
    end else begin
      v1_q  <= accept;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      vl_q[0] <= v7_q;
      for (int i = 1; i < DL; i++) vl_q[i] <= vl_q[i-1];
      vp1_q <= vl_q[DL-1];
      vp2_q <= vp1_q;
      vp3_q <= vp2_q;
      vp4_q <= vp3_q;
      vp5_q <= vp4_q;
    end
  end

  assign done_o       = vp5_q;
  assign union_area_o = union_q;
  assign relation_o   = relo_q;

endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for two_circle_union_area: directed table, then random circle pairs
// depends on uca_pkg (rel_e, AREA_WIDTH) and the two_circle_union_area top level
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned STEPS      = uca_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned AW         = uca_pkg::AREA_WIDTH;
  localparam int unsigned NORM       = 31;
  localparam longint      PI_ANGLE   = 52707179;
  localparam int unsigned TAIL       = 120;   // extra wait after the last result
  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned RAND_ITEMS = 700;

  // arctangent of 2^-i in q2.24
  localparam longint ATAN_TBL [0:24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  typedef struct {
    logic signed [15:0] x1, y1, x2, y2;
    logic [14:0]        r1, r2;
  } pair_t;

  typedef struct {
    logic [AW-1:0]   area;
    uca_pkg::rel_e   rel;
  } area_res_t;

  typedef struct {
    pair_t           p;
    bit              typed;   // expected result given in the row
    logic [AW-1:0]   area;
    uca_pkg::rel_e   rel;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic [14:0] first_radius_i = '0, second_radius_i = '0;
  logic done_o;
  logic [AW-1:0] union_area_o;
  logic [1:0] relation_o;

  area_res_t pending_areas[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;

  two_circle_union_area i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .first_x_i, .first_y_i, .first_radius_i,
    .second_x_i, .second_y_i, .second_radius_i,
    .done_o, .union_area_o, .relation_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- predictor ----------------

  function automatic longint unsigned circle_q8(input longint unsigned r);
    return (r * r * 80384 + 50) / 100;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring cordic on (adjacent, opposite), folded to [0, pi] for an obtuse side
  function automatic longint unsigned half_angle_q24(input longint unsigned adj, input bit neg,
                                                     input longint unsigned opp);
    longint x, y, z, xs, ys;
    x = adj;
    y = opp;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end
    end
    if (neg) z = PI_ANGLE - z;
    if (z < 0) z = 0;
    if (z > PI_ANGLE) z = PI_ANGLE;
    return z;
  endfunction

  function automatic area_res_t predict_union(input pair_t c);
    area_res_t res;
    longint dx, dy, n1, n2;
    longint unsigned d2, r1, r2, rs, rd, a1, a2, p, q, m1, m2, mx, h, hterm, tot, lens;
    int sh, len;
    r1 = c.r1;
    r2 = c.r2;
    dx = longint'(c.x2) - longint'(c.x1);
    dy = longint'(c.y2) - longint'(c.y1);
    d2 = dx * dx + dy * dy;
    rs = r1 + r2;
    rd = (r1 > r2) ? r1 - r2 : r2 - r1;
    a1 = circle_q8(r1);
    a2 = circle_q8(r2);
    if (d2 >= rs * rs) begin
      res.rel = uca_pkg::REL_DISJOINT;
      res.area = AW'(a1 + a2);
    end else if (d2 <= rd * rd) begin
      res.rel = uca_pkg::REL_INSIDE;
      res.area = AW'((a1 > a2) ? a1 : a2);
    end else begin
      p = d2 - rd * rd;
      q = rs * rs - d2;
      n1 = longint'(r1 * r1) - longint'(r2 * r2) + longint'(d2);
      n2 = longint'(r2 * r2) - longint'(r1 * r1) + longint'(d2);
      m1 = (n1 < 0) ? -n1 : n1;
      m2 = (n2 < 0) ? -n2 : n2;
      mx = p;
      if (q > mx) mx = q;
      if (m1 > mx) mx = m1;
      if (m2 > mx) mx = m2;
      len = 0;
      while (mx != 0) begin
        len++;
        mx >>= 1;
      end
      // normalize so the largest operand has exactly 31 bits
      sh = len - NORM;
      if (sh < 0) begin
        p <<= -sh; q <<= -sh; m1 <<= -sh; m2 <<= -sh;
      end else begin
        p >>= sh; q >>= sh; m1 >>= sh; m2 >>= sh;
      end
      h = floor_root(p * q);
      hterm = h << 7;
      if (sh > 0) hterm <<= sh;
      else if (sh < 0) hterm = (hterm + (64'd1 << (-sh - 1))) >> -sh;
      tot = ((r1 * r1 * half_angle_q24(m1, n1 < 0, h) + (64'd1 << 15)) >> 16)
          + ((r2 * r2 * half_angle_q24(m2, n2 < 0, h) + (64'd1 << 15)) >> 16);
      lens = (tot > hterm) ? tot - hterm : 0;
      res.rel = uca_pkg::REL_OVERLAP;
      res.area = AW'((a1 + a2 > lens) ? a1 + a2 - lens : 0);
    end
    return res;
  endfunction

  // ---------------- stimulus ----------------

  function automatic pair_t mk(input int x1, y1, r1, x2, y2, r2);
    pair_t c;
    c.x1 = 16'(x1); c.y1 = 16'(y1); c.r1 = 15'(r1);
    c.x2 = 16'(x2); c.y2 = 16'(y2); c.r2 = 15'(r2);
    return c;
  endfunction

  function automatic pair_t random_pair();
    pair_t c;
    int unsigned mode, lim1, lim2, reach;
    mode = $urandom_range(0, 9);
    c.x1 = 16'($urandom);
    c.y1 = 16'($urandom);
    lim1 = ($urandom_range(0, 3) == 0) ? 255 : 32767;
    lim2 = ($urandom_range(0, 3) == 0) ? 255 : 32767;
    c.r1 = 15'($urandom_range(0, lim1));
    c.r2 = 15'($urandom_range(0, lim2));
    if (mode < 2) begin
      // raw noise: every bit of every field toggles
      c.x2 = 16'($urandom); c.y2 = 16'($urandom);
      c.r1 = 15'($urandom); c.r2 = 15'($urandom);
    end else if (mode == 9) begin
      c.x2 = c.x1; c.y2 = c.y1;   // concentric
    end else begin
      // center offset within reach of the radius sum, so most pairs overlap
      reach = int'(c.r1) + int'(c.r2);
      c.x2 = 16'(int'(c.x1) + int'($urandom_range(0, 2 * reach)) - int'(reach));
      c.y2 = 16'(int'(c.y1) + int'($urandom_range(0, reach / 2)));
    end
    return c;
  endfunction

  // one transfer: drive at the falling edge, accepted at the rising edge with busy low
  task automatic send_pair(input pair_t c, input bit typed, input area_res_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    first_x_i <= c.x1; first_y_i <= c.y1; first_radius_i <= c.r1;
    second_x_i <= c.x2; second_y_i <= c.y2; second_radius_i <= c.r2;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_areas.push_back(typed ? want : predict_union(c));
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // ---------------- result check ----------------

  always @(posedge clk_i) begin
    area_res_t e;
    if (rst_ni && done_o) begin
      if (pending_areas.size() == 0) begin
        report_mismatch("unexpected result, area", 64'(union_area_o), 64'd0);
      end else begin
        e = pending_areas.pop_front();
        if (union_area_o !== e.area) begin
          report_mismatch("union_area", 64'(union_area_o), 64'(e.area));
        end
        if (relation_o !== e.rel) report_mismatch("relation", 64'(relation_o), 64'(e.rel));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    area_res_t want;
    // directed rows; results typed in only for the obvious ones
    r.typed = 1;
    r.p = mk(0, 0, 0, 0, 0, 0);                  r.area = '0;   r.rel = uca_pkg::REL_DISJOINT;
    rows.push_back(r);
    r.p = mk(5, 5, 32767, 5, 5, 32767);          r.area = 41'd863063948150;
    r.rel = uca_pkg::REL_INSIDE;                 rows.push_back(r);
    r.p = mk(-32768, -32768, 1, 32767, 32767, 1); r.area = 41'd1608;
    r.rel = uca_pkg::REL_DISJOINT;
    rows.push_back(r);
    r.p = mk(0, 0, 3, 5, 0, 2);                  r.area = 41'd10450;
    r.rel = uca_pkg::REL_DISJOINT;
    rows.push_back(r);   // externally tangent
    r.p = mk(0, 0, 5, 3, 0, 2);                  r.area = 41'd20096;
    r.rel = uca_pkg::REL_INSIDE;
    rows.push_back(r);   // internally tangent
    r.p = mk(7, 7, 0, 7, 7, 9);                  r.area = 41'd65111;
    r.rel = uca_pkg::REL_INSIDE;
    rows.push_back(r);
    r.typed = 0;
    rows.push_back('{p: mk(0, 0, 10, 10, 0, 10), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});
    rows.push_back('{p: mk(0, 0, 1, 1, 0, 1), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});
    rows.push_back('{p: mk(-32768, 0, 32767, 32767, 0, 32767), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});
    rows.push_back('{p: mk(0, 0, 32767, 1, 1, 32766), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});
    rows.push_back('{p: mk(32767, -32768, 32767, -32768, 32767, 32767), typed: 0,
                     area: '0, rel: uca_pkg::REL_OVERLAP});
    rows.push_back('{p: mk(100, 100, 50, 130, 140, 1), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});
    rows.push_back('{p: mk(0, 0, 20000, 30000, 0, 12000), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});  // both half-angles acute
    rows.push_back('{p: mk(-1, -1, 2, 1, 1, 2), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});
    rows.push_back('{p: mk(0, 0, 32767, 32767, 32767, 32767), typed: 0, area: '0,
                     rel: uca_pkg::REL_OVERLAP});

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      want.area = rows[i].area;
      want.rel = rows[i].rel;
      send_pair(rows[i].p, rows[i].typed, want);
    end

    // three idle phases: light gaps, heavy gaps, back to back
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 6 : (ph == 1) ? 59 : 0;
      for (int n = 0; n < RAND_ITEMS / 3; n++) send_pair(random_pair(), 0, want);
      if (ph == 0) begin
        // hold off until the pipeline has drained
        @(negedge clk_i);
        start <= 1'b0;
        while (pending_areas.size() != 0) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (pending_areas.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
